FILE: design/ip_header_strip_obfuscator_core_assert.svh
// assertion macros shared by the front and queue rtl files
`ifndef IP_HEADER_STRIP_OBFUSCATOR_CORE_ASSERT_SVH
`define IP_HEADER_STRIP_OBFUSCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define IHSO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define IHSO_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define IHSO_ASSERT(lbl, prop)
`define IHSO_ASSERT_NEVER(lbl, expr)
`endif

`endif

FILE: design/ihso_pkg.sv
`timescale 1ns / 1ps
package ihso_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 2048;
  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_BADV  = 2'd2;

  localparam logic [0:0] REG_LOCAL_V6_PREFIX = 1'd0;
  localparam logic [0:0] REG_XOR_KEY         = 1'd1;

  localparam logic [31:0] PREFIX_RESET  = 32'd872567522;
  localparam logic [7:0]  XOR_KEY_RESET = 8'd15;

  typedef struct packed {
    logic [1:0] status;
    logic       last;
    logic [7:0] data;
  } out_item_t;

  typedef struct packed {
    logic [31:0] local_v6_prefix;
    logic [7:0]  xor_key;
  } cfg_t;

endpackage

FILE: design/ihso_front.sv
`timescale 1ns / 1ps
`include "ip_header_strip_obfuscator_core_assert.svh"
module ihso_front import ihso_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic      in_last_i,
  output logic      push_o,
  output out_item_t push_item_o,
  input  logic      full_i
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DEC  = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_V4   = 2'd1;
  localparam logic [1:0] MODE_V6   = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       mode_q, mode_d;
  logic [7:0]       proto_q, proto_d;
  logic [15:0]      plen_q, plen_d;
  logic [15:0]      dport_q, dport_d;
  logic [7:0]       tag_q, tag_d;
  logic [15:0]      xrem_q, xrem_d;
  logic             fin_pend_q, fin_pend_d;
  logic             v6_q, v6_d;

  logic [7:0] src_q [16];
  logic [7:0] dst_q [16];
  logic [7:0] early_q [8];

  logic             accept, live, is_v4, is_v6, decide, payload_now;
  logic             obf, is_local, short_pkt, bad_ver;
  logic [1:0]       mode_n, mode_eff;
  logic [15:0]      dport_full;
  logic [31:0]      dst_word;
  logic [POS_W-1:0] count;
  logic [POS_W-1:0] src_off, dst_off, early_off;
  logic [4:0]       alen;
  logic [7:0]       early_sel, src_sel;

  assign in_ready_o = (phase_q == PH_IDLE) && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign live       = pos_q < POS_W'(MAX_PACKET_BYTES);

  always_comb begin
    if (pos_q == '0) begin
      case (in_byte_i[7:4])
        4'h4:    mode_n = MODE_V4;
        4'h6:    mode_n = MODE_V6;
        default: mode_n = MODE_BAD;
      endcase
    end else begin
      mode_n = mode_q;
    end
  end

  assign mode_eff = live ? mode_n : mode_q;
  assign is_v4    = live && (mode_n == MODE_V4);
  assign is_v6    = live && (mode_n == MODE_V6);
  assign decide   = accept && ((is_v4 && pos_q == POS_W'(27)) ||
                               (is_v6 && pos_q == POS_W'(43)));
  assign payload_now = accept && ((is_v4 && pos_q >= POS_W'(28)) ||
                                  (is_v6 && pos_q >= POS_W'(44)));

  // classification of the held header
  assign dport_full = is_v6 ? {dport_q[15:8], in_byte_i} : dport_q;
  assign obf = (proto_q == 8'd17 && dport_full == 16'd53) ||
               (proto_q == 8'd6 && dport_full == 16'd443) ||
               (proto_q == 8'd6 && dport_full == 16'd80) ||
               (proto_q == 8'd58);
  assign dst_word = {dst_q[0], dst_q[1], dst_q[2], dst_q[3]};
  assign is_local = is_v6 ? (dst_word == cfg_i.local_v6_prefix)
                  : ((dst_word & 32'hff000000) == 32'h0a000000) ||
                    ((dst_word & 32'hfff00000) == 32'hac100000) ||
                    ((dst_word & 32'hffff0000) == 32'hc0a80000);

  assign count     = live ? pos_q + POS_W'(1) : pos_q;
  assign short_pkt = (count < POS_W'(28)) || (mode_eff == MODE_V6 && count < POS_W'(44));
  assign bad_ver   = (mode_eff != MODE_V4) && (mode_eff != MODE_V6);

  assign alen      = v6_q ? 5'd16 : 5'd4;
  assign early_sel = v6_q ? early_q[3'(cnt_q - 5'd8)] : early_q[3'(cnt_q - 5'd4)];
  assign src_sel   = v6_q ? src_q[{1'b1, cnt_q[2:0]}] : src_q[{2'b00, cnt_q[1:0]}];

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    mode_d      = mode_q;
    proto_d     = proto_q;
    plen_d      = plen_q;
    dport_d     = dport_q;
    tag_d       = tag_q;
    xrem_d      = xrem_q;
    fin_pend_d  = fin_pend_q;
    v6_d        = v6_q;
    push_o      = 1'b0;
    push_item_o = '0;
    case (phase_q)
      PH_IDLE: begin
        if (accept) begin
          if (live) begin
            mode_d = mode_n;
            pos_d  = pos_q + POS_W'(1);
            if (is_v4) begin
              if (pos_q == POS_W'(2)) plen_d = {in_byte_i, 8'h00};
              if (pos_q == POS_W'(3)) plen_d = {plen_q[15:8], in_byte_i} - 16'd20;
              if (pos_q == POS_W'(9)) proto_d = in_byte_i;
              if (pos_q == POS_W'(22)) dport_d = {in_byte_i, 8'h00};
              if (pos_q == POS_W'(23)) dport_d = {dport_q[15:8], in_byte_i};
            end
            if (is_v6) begin
              if (pos_q == POS_W'(4)) plen_d = {in_byte_i, 8'h00};
              if (pos_q == POS_W'(5)) plen_d = {plen_q[15:8], in_byte_i};
              if (pos_q == POS_W'(6)) proto_d = in_byte_i;
              if (pos_q == POS_W'(42)) dport_d = {in_byte_i, 8'h00};
              if (pos_q == POS_W'(43)) dport_d = dport_full;
            end
          end
          if (decide) begin
            tag_d      = (is_v6 ? (obf ? 8'h9f : 8'h60) : (obf ? 8'hbf : 8'h40))
                         ^ (is_local ? 8'h08 : 8'h00);
            xrem_d     = obf ? plen_q : 16'd0;
            phase_d    = PH_DEC;
            cnt_d      = '0;
            fin_pend_d = in_last_i;
            v6_d       = is_v6;
          end
          if (payload_now) begin
            push_o           = 1'b1;
            push_item_o.data = (xrem_q != 16'd0) ? (in_byte_i ^ cfg_i.xor_key) : in_byte_i;
            if (xrem_q != 16'd0) xrem_d = xrem_q - 16'd1;
          end
          if (in_last_i) begin
            pos_d  = '0;
            mode_d = MODE_NONE;
            v6_d   = (mode_eff == MODE_V6);
            if (short_pkt || bad_ver) begin
              push_o             = 1'b1;
              push_item_o.last   = 1'b1;
              push_item_o.status = short_pkt ? STATUS_SHORT : STATUS_BADV;
            end else if (!decide) begin
              phase_d = PH_FIN;
              cnt_d   = '0;
            end
          end
        end
      end
      PH_DEC: begin
        // held source bytes, then early payload bytes
        if (!full_i) begin
          push_o = 1'b1;
          if (cnt_q < (v6_q ? 5'd8 : 5'd4)) begin
            push_item_o.data = src_sel;
          end else begin
            push_item_o.data = (xrem_q != 16'd0) ? (early_sel ^ cfg_i.xor_key) : early_sel;
            if (xrem_q != 16'd0) xrem_d = xrem_q - 16'd1;
          end
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'd11) begin
            cnt_d   = '0;
            phase_d = fin_pend_q ? PH_FIN : PH_IDLE;
          end
        end
      end
      PH_FIN: begin
        // trailer: destination, tag, protocol, length
        if (!full_i) begin
          push_o = 1'b1;
          cnt_d  = cnt_q + 5'd1;
          if (cnt_q < alen) begin
            push_item_o.data = dst_q[cnt_q[3:0]];
          end else if (cnt_q == alen) begin
            push_item_o.data = tag_q;
          end else if (cnt_q == alen + 5'd1) begin
            push_item_o.data = proto_q;
          end else if (cnt_q == alen + 5'd2) begin
            push_item_o.data = plen_q[15:8];
          end else begin
            push_item_o.data = plen_q[7:0];
            push_item_o.last = 1'b1;
            cnt_d            = '0;
            phase_d          = PH_IDLE;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      cnt_q      <= '0;
      pos_q      <= '0;
      mode_q     <= MODE_NONE;
      proto_q    <= '0;
      plen_q     <= '0;
      dport_q    <= '0;
      tag_q      <= '0;
      xrem_q     <= '0;
      fin_pend_q <= 1'b0;
      v6_q       <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      mode_q     <= mode_d;
      proto_q    <= proto_d;
      plen_q     <= plen_d;
      dport_q    <= dport_d;
      tag_q      <= tag_d;
      xrem_q     <= xrem_d;
      fin_pend_q <= fin_pend_d;
      v6_q       <= v6_d;
    end
  end

  assign src_off   = is_v6 ? pos_q - POS_W'(8) : pos_q - POS_W'(12);
  assign dst_off   = is_v6 ? pos_q - POS_W'(24) : pos_q - POS_W'(16);
  assign early_off = is_v6 ? pos_q - POS_W'(40) : pos_q - POS_W'(20);

  // header stores, swapped in place for a local destination
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 16; i++) begin
        if (((is_v4 && pos_q >= POS_W'(12) && pos_q < POS_W'(16)) ||
             (is_v6 && pos_q >= POS_W'(8) && pos_q < POS_W'(24))) &&
            src_off[3:0] == 4'(i)) begin
          src_q[i] <= in_byte_i;
        end
        if (((is_v4 && pos_q >= POS_W'(16) && pos_q < POS_W'(20)) ||
             (is_v6 && pos_q >= POS_W'(24) && pos_q < POS_W'(40))) &&
            dst_off[3:0] == 4'(i)) begin
          dst_q[i] <= in_byte_i;
        end
        if (decide && is_local && (is_v6 || i < 4)) begin
          src_q[i] <= dst_q[i];
          dst_q[i] <= src_q[i];
        end
      end
      for (int j = 0; j < 8; j++) begin
        if (((is_v4 && pos_q >= POS_W'(20) && pos_q < POS_W'(28)) ||
             (is_v6 && pos_q >= POS_W'(40) && pos_q < POS_W'(44))) &&
            early_off[2:0] == 3'(j)) begin
          early_q[j] <= in_byte_i;
        end
      end
    end
  end

  `IHSO_ASSERT(a_err_is_last, push_o && push_item_o.status != STATUS_OK |-> push_item_o.last)
  `IHSO_ASSERT(a_fin_clears_pos, $past(phase_q == PH_FIN) && phase_q == PH_IDLE |-> pos_q == '0)
  `IHSO_ASSERT_NEVER(a_dec_no_last, phase_q == PH_DEC && push_o && push_item_o.last)

endmodule

FILE: design/ihso_queue.sv
`timescale 1ns / 1ps
`include "ip_header_strip_obfuscator_core_assert.svh"
module ihso_queue import ihso_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t item_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  out_item_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]         cnt_q, cnt_d;
  logic                   pop, push;

  assign full_o  = cnt_q == (PTR_W + 1)'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign push    = push_i && !full_o;

  always_comb begin
    wr_d  = push ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end

  `IHSO_ASSERT_NEVER(a_cnt_range, cnt_q > (PTR_W + 1)'(QUEUE_DEPTH))
  `IHSO_ASSERT(a_ptr_gap, cnt_q != (PTR_W + 1)'(QUEUE_DEPTH) |-> cnt_q[PTR_W-1:0] == wr_q - rd_q)

endmodule

FILE: design/ip_header_strip_obfuscator_core.sv
`timescale 1ns / 1ps
// output: a payload byte is registered in the output queue on its transfer; header bytes are held
// throughput: 1 byte per cycle while the queue is not full, except while the front sequencer
// emits its bursts after the port-holding byte and after the final byte
// reset: asynchronous active low; clears packet state and queue, registers to reset values
module ip_header_strip_obfuscator_core import ihso_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // configuration registers
  cfg_t      cfg_q;
  // front to queue transfer
  logic      push;
  logic      full;
  out_item_t push_item;
  out_item_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_v6_prefix <= PREFIX_RESET;
      cfg_q.xor_key         <= XOR_KEY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOCAL_V6_PREFIX: cfg_q.local_v6_prefix <= cfg_data_i;
        REG_XOR_KEY:         cfg_q.xor_key <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // front: parses the header, classifies and sequences the output bursts
  ihso_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  // back: short queue that drives the output stream
  ihso_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .item_o  (head)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tlast = head.last;
  assign m_axis_tuser = head.status;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ihso_pkg::*;

  localparam int unsigned HDR_V4 = 28;
  localparam int unsigned HDR_V6 = 44;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // in_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_byte
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;        // status
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = REG_LOCAL_V6_PREFIX;
  logic [31:0] cfg_data_i = '0;

  int unsigned errors = 0;
  bit          hold_rx = 1'b0;      // long receiver hold-off request
  bit          quiet = 1'b0;        // no idling on either side

  ip_header_strip_obfuscator_core dut (.*);

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor: mirror of the re-framer with its own state and register copies
  // ---------------------------------------------------------------------------
  logic [31:0] m_prefix;
  logic [7:0]  m_key;
  logic [15:0] m_pos;
  logic [1:0]  m_mode;
  logic [7:0]  m_proto;
  logic [15:0] m_plen;
  logic [15:0] m_port;
  logic [7:0]  m_src [16];
  logic [7:0]  m_dst [16];
  logic [7:0]  m_early [8];
  logic [7:0]  m_tag;
  logic [15:0] m_xor_left;

  out_item_t   frame_q [$];         // tunnel bytes still awaited from the block

  function automatic void push_frame(logic [7:0] d, logic l, logic [1:0] s);
    out_item_t it;
    it.data = d; it.last = l; it.status = s;
    frame_q.push_back(it);
  endfunction

  function automatic logic [7:0] scramble(logic [7:0] b);
    if (m_xor_left != 0) begin
      m_xor_left--;
      return b ^ m_key;
    end
    return b;
  endfunction

  function automatic void clear_pkt();
    m_pos = 0; m_mode = 0; m_proto = 0; m_plen = 0; m_port = 0;
    m_tag = 0; m_xor_left = 0;
  endfunction

  // classification at the hold point, then the source bytes and early payload
  function automatic void classify_and_emit();
    bit v6, obf, loc;
    int alen;
    logic [31:0] d;
    logic [7:0] t;
    v6 = (m_mode == 2);
    alen = v6 ? 16 : 4;
    obf = (m_proto == 17 && m_port == 53) || (m_proto == 6 && m_port == 443) ||
          (m_proto == 6 && m_port == 80) || (m_proto == 58);
    d = {m_dst[0], m_dst[1], m_dst[2], m_dst[3]};
    if (v6) begin
      m_tag = obf ? 8'h9f : 8'h60;
      loc = (d == m_prefix);
    end else begin
      m_tag = obf ? 8'hbf : 8'h40;
      loc = (d[31:24] == 8'h0a) || ((d & 32'hfff00000) == 32'hac100000) ||
            (d[31:16] == 16'hc0a8);
    end
    if (loc) begin
      m_tag ^= 8'h08;
      for (int i = 0; i < alen; i++) begin
        t = m_src[i]; m_src[i] = m_dst[i]; m_dst[i] = t;
      end
    end
    m_xor_left = obf ? m_plen : 16'd0;
    if (v6) begin
      for (int i = 8; i < 16; i++) push_frame(m_src[i], 1'b0, STATUS_OK);
      for (int i = 0; i < 4; i++) push_frame(scramble(m_early[i]), 1'b0, STATUS_OK);
    end else begin
      for (int i = 0; i < 4; i++) push_frame(m_src[i], 1'b0, STATUS_OK);
      for (int i = 0; i < 8; i++) push_frame(scramble(m_early[i]), 1'b0, STATUS_OK);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic lst);
    int p;
    int alen;
    p = m_pos;
    if (p < MAX_PACKET_BYTES) begin
      if (p == 0) m_mode = (b[7:4] == 4'h4) ? 2'd1 : (b[7:4] == 4'h6) ? 2'd2 : 2'd3;
      if (m_mode == 1) begin
        if (p == 2) m_plen = {b, 8'h00};
        else if (p == 3) m_plen = (m_plen | b) - 16'd20;
        else if (p == 9) m_proto = b;
        else if (p >= 12 && p < 16) m_src[p-12] = b;
        else if (p >= 16 && p < 20) m_dst[p-16] = b;
        if (p >= 20 && p < HDR_V4) begin
          m_early[p-20] = b;
          if (p == 22) m_port = {b, 8'h00};
          if (p == 23) m_port[7:0] = b;
          if (p == 27) classify_and_emit();
        end else if (p >= HDR_V4) push_frame(scramble(b), 1'b0, STATUS_OK);
      end else if (m_mode == 2) begin
        if (p == 4) m_plen = {b, 8'h00};
        else if (p == 5) m_plen[7:0] = b;
        else if (p == 6) m_proto = b;
        else if (p >= 8 && p < 24) m_src[p-8] = b;
        else if (p >= 24 && p < 40) m_dst[p-24] = b;
        if (p >= 40 && p < HDR_V6) begin
          m_early[p-40] = b;
          if (p == 42) m_port = {b, 8'h00};
          if (p == 43) begin
            m_port[7:0] = b;
            classify_and_emit();
          end
        end else if (p >= HDR_V6) push_frame(scramble(b), 1'b0, STATUS_OK);
      end
      m_pos = p + 1;
    end
    if (lst) begin
      alen = (m_mode == 2) ? 16 : 4;
      if (m_pos < HDR_V4 || (m_mode == 2 && m_pos < HDR_V6))
        push_frame(8'h00, 1'b1, STATUS_SHORT);
      else if (m_mode != 1 && m_mode != 2)
        push_frame(8'h00, 1'b1, STATUS_BADV);
      else begin
        for (int i = 0; i < alen; i++) push_frame(m_dst[i], 1'b0, STATUS_OK);
        push_frame(m_tag, 1'b0, STATUS_OK);
        push_frame(m_proto, 1'b0, STATUS_OK);
        push_frame(m_plen[15:8], 1'b0, STATUS_OK);
        push_frame(m_plen[7:0], 1'b1, STATUS_OK);
      end
      clear_pkt();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one byte per call, bursts with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_byte(logic [7:0] b, logic lst);
    if (!quiet && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_byte(b, lst);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern plus an optional long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || hold_rx) m_axis_tready <= 1'b0;
    else if (quiet) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // result checker against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_q.size() == 0) begin
        $error("unexpected transfer: data %h last %b status %0d",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        errors++;
      end else begin
        want = frame_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %h actual %h", want.data, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last: expected %b actual %b", want.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // packet builders
  // ---------------------------------------------------------------------------
  typedef logic [7:0] byte_q_t [$];

  function automatic byte_q_t make_v4(logic [7:0] proto, logic [15:0] port,
                                      logic [31:0] dst, logic [15:0] tot_len,
                                      int pay_len);
    byte_q_t p;
    for (int i = 0; i < 20 + pay_len; i++) p.push_back($urandom_range(0, 255));
    p[0] = {4'h4, p[0][3:0]};
    p[2] = tot_len[15:8]; p[3] = tot_len[7:0];
    p[9] = proto;
    {p[16], p[17], p[18], p[19]} = dst;
    if (pay_len >= 4) begin
      p[22] = port[15:8]; p[23] = port[7:0];
    end
    return p;
  endfunction

  function automatic byte_q_t make_v6(logic [7:0] proto, logic [15:0] port,
                                      logic [31:0] dst_hi, logic [15:0] plen,
                                      int pay_len);
    byte_q_t p;
    for (int i = 0; i < 40 + pay_len; i++) p.push_back($urandom_range(0, 255));
    p[0] = {4'h6, p[0][3:0]};
    p[4] = plen[15:8]; p[5] = plen[7:0];
    p[6] = proto;
    {p[24], p[25], p[26], p[27]} = dst_hi;
    if (pay_len >= 4) begin
      p[42] = port[15:8]; p[43] = port[7:0];
    end
    return p;
  endfunction

  task automatic send_packet(byte_q_t p);
    foreach (p[i]) send_byte(p[i], i == p.size() - 1);
  endtask

  // random but mostly well formed packet
  function automatic byte_q_t random_packet(int max_pay);
    logic [7:0] proto;
    logic [15:0] port;
    logic [31:0] dst;
    int pay;
    byte_q_t p;
    case ($urandom_range(0, 3))
      0: begin proto = 8'd17; port = 16'd53; end
      1: begin proto = 8'd6; port = $urandom_range(0, 1) ? 16'd443 : 16'd80; end
      2: begin proto = 8'd58; port = $urandom_range(0, 65535); end
      default: begin proto = $urandom_range(0, 255); port = $urandom_range(0, 65535); end
    endcase
    pay = $urandom_range(0, max_pay);
    case ($urandom_range(0, 4))
      0: dst = {8'h0a, 24'($urandom())};
      1: dst = {12'hac1, 20'($urandom())};
      2: dst = {16'hc0a8, 16'($urandom())};
      default: dst = $urandom();
    endcase
    if ($urandom_range(0, 9) < 6) begin
      pay = pay + 8;
      p = make_v4(proto, port, dst, 16'(20 + $urandom_range(0, pay + 4)), pay);
    end else if ($urandom_range(0, 4) != 0) begin
      pay = pay + 4;
      if ($urandom_range(0, 1)) dst = m_prefix;
      p = make_v6(proto, port, dst, 16'($urandom_range(0, pay + 4)), pay);
    end else begin
      // noise: truncated or bad version
      pay = $urandom_range(1, 50);
      for (int i = 0; i < pay; i++) p.push_back($urandom_range(0, 255));
    end
    return p;
  endfunction

  // registers are written only with the block idle
  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LOCAL_V6_PREFIX) m_prefix = val;
    else m_key = val[7:0];
  endtask

  task automatic drain();
    go_idle();
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    quiet = 1'b1;
    send_packet(make_v4(8'd17, 16'd53, 32'h0a000001, 16'd30, 10));     // dns, local
    send_packet(make_v4(8'd6, 16'd443, 32'h08080808, 16'd0, 12));      // length wraps
    send_packet(make_v4(8'd6, 16'd80, 32'hac1f0000, 16'hffff, 8));     // xor past payload
    send_packet(make_v4(8'd255, 16'hffff, 32'hc0a8ffff, 16'd24, 8));
    send_packet(make_v6(8'd58, 16'd1, m_prefix, 16'd3, 6));            // icmpv6, local
    send_packet(make_v6(8'd6, 16'd443, 32'h0, 16'hffff, 4));
    quiet = 1'b0;
    send_packet(make_v6(8'd17, 16'd53, ~m_prefix, 16'd0, 5));
    send_byte(8'h45, 1'b1);                                            // one-byte packet
    send_packet(make_v4(8'd6, 16'd80, 32'h0, 16'd40, 7));               // 27 bytes: short
    send_packet(make_v6(8'd6, 16'd80, 32'h0, 16'd40, 3));               // 43 bytes: short
    begin
      byte_q_t p;
      for (int i = 0; i < 28; i++) p.push_back(8'hff);
      p[0] = 8'h15;                                                    // bad version
      send_packet(p);
      p[0] = 8'hf0;
      send_packet(p);
    end
    drain();
  endtask

  task automatic test_random(int n_items);
    int sent;
    byte_q_t p;
    sent = 0;
    while (sent < n_items) begin
      p = random_packet(24);
      send_packet(p);
      sent += p.size();
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        quiet = 1'b1;
        repeat (2) send_packet(random_packet(8));
        quiet = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    clear_pkt();
    m_prefix = PREFIX_RESET;
    m_key = XOR_KEY_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_reg(REG_XOR_KEY, 32'h000000ff);
    write_reg(REG_LOCAL_V6_PREFIX, 32'hffffffff);
    test_backpressure();
    write_reg(REG_XOR_KEY, $urandom());
    write_reg(REG_LOCAL_V6_PREFIX, $urandom());
    test_random(40);

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: ip_header_strip_obfuscator_core.f
+incdir+design
design/ihso_pkg.sv
design/ihso_front.sv
design/ihso_queue.sv
design/ip_header_strip_obfuscator_core.sv
dv/tb.sv
